FILE: hdl/tksi_pkg.sv
// ----------------------------------------------------------------------------
// tksi_pkg
// Shared types and constants for the top-K sorted insertion list.
// ----------------------------------------------------------------------------
package tksi_pkg;

    localparam int KIND_W   = 2;
    localparam int LABEL_W  = 16;
    localparam int AMOUNT_W = 48;
    localparam int RANK_W   = 6;

    typedef enum logic [KIND_W-1:0] {
        KIND_OFFER = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // controller -> list datapath
    typedef struct packed {
        logic insert;
        logic clear;
        logic rotate;
    } t_list_cmd;

endpackage

FILE: hdl/tksi_ctrl.sv
// ----------------------------------------------------------------------------
// tksi_ctrl
// Request sequencer: decodes input requests and walks the readout.
// ----------------------------------------------------------------------------
module tksi_ctrl
    import tksi_pkg::*;
#(
    parameter int LIST_DEPTH = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [RANK_W-1:0] o_rank,
    output logic              o_last,
    output t_list_cmd         o_cmd
);

    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(LIST_DEPTH - 1);

    t_state            r_state, n_state;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic              accept;
    logic              at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_rank  <= n_rank;
        end
    end

    assign at_last = (r_rank == LAST_RANK);

    always_comb begin
        n_state    = r_state;
        n_rank     = r_rank;
        o_ready    = 1'b0;
        o_out_valid = 1'b0;
        o_cmd      = '0;
        accept     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                accept  = i_valid;
                if (accept) begin
                    case (t_kind'(i_kind))
                        KIND_OFFER: o_cmd.insert = 1'b1;
                        KIND_CLEAR: o_cmd.clear  = 1'b1;
                        KIND_READ: begin
                            n_state = ST_READ;
                            n_rank  = '0;
                        end
                        default: ;  // unused kind: dropped
                    endcase
                end
            end
            ST_READ: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    // rotate so the next rank sits in cell 0
                    o_cmd.rotate = 1'b1;
                    n_rank       = r_rank + 1'b1;
                    if (at_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_rank = r_rank;
    assign o_last = at_last;

endmodule

FILE: hdl/tksi_list.sv
// ----------------------------------------------------------------------------
// tksi_list
// Row of list cells: parallel compare/shift insert, clear, and rotate.
// ----------------------------------------------------------------------------
module tksi_list
    import tksi_pkg::*;
#(
    parameter int LIST_DEPTH = 50
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_list_cmd           i_cmd,
    input  logic [LABEL_W-1:0]  i_label,
    input  logic [AMOUNT_W-1:0] i_amount,
    output logic [LABEL_W-1:0]  o_head_label,
    output logic [AMOUNT_W-1:0] o_head_amount
);

    logic [LABEL_W-1:0]  r_label  [LIST_DEPTH];
    logic [AMOUNT_W-1:0] r_amount [LIST_DEPTH];
    logic [LABEL_W-1:0]  n_label  [LIST_DEPTH];
    logic [AMOUNT_W-1:0] n_amount [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] gt;     // cell strictly above offer
    logic [LIST_DEPTH-1:0] gt_up;  // same flag of the cell one rank up

    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            gt[i] = (r_amount[i] > i_amount);
        end
        gt_up[0] = 1'b1;
        for (int i = 1; i < LIST_DEPTH; i++) begin
            gt_up[i] = gt[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            n_label[i]  = r_label[i];
            n_amount[i] = r_amount[i];
            if (i_cmd.clear) begin
                n_label[i]  = '0;
                n_amount[i] = '0;
            end else if (i_cmd.rotate) begin
                n_label[i]  = r_label[(i + 1) % LIST_DEPTH];
                n_amount[i] = r_amount[(i + 1) % LIST_DEPTH];
            end else if (i_cmd.insert && !gt[i]) begin
                // list is sorted, so gt is a run of ones then zeros
                if (gt_up[i]) begin
                    n_label[i]  = i_label;
                    n_amount[i] = i_amount;
                end else begin
                    n_label[i]  = r_label[(i + LIST_DEPTH - 1) % LIST_DEPTH];
                    n_amount[i] = r_amount[(i + LIST_DEPTH - 1) % LIST_DEPTH];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (!i_rst_n) begin
                r_label[i]  <= '0;
                r_amount[i] <= '0;
            end else begin
                r_label[i]  <= n_label[i];
                r_amount[i] <= n_amount[i];
            end
        end
    end

    assign o_head_label  = r_label[0];
    assign o_head_amount = r_amount[0];

endmodule

FILE: hdl/top_k_sorted_insert.sv
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Keeps the LIST_DEPTH largest amounts with labels, sorted descending.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  input   | i_valid / o_ready  | i_kind, i_label, i_amount
//  output  | o_valid / i_ready  | o_rank, o_entry_label, o_entry_amount, o_last
//
//  Offer and clear requests can arrive back to back.
//  A read request emits LIST_DEPTH results, one per output handshake; the
//  input side is held off until the last one is taken. Readout rotates the
//  cell row by one rank per result, so after a full read the list is back in
//  order. Synchronous active-low reset zeroes every cell.
//  Output stalls simply freeze the rotation; nothing is lost.
// ----------------------------------------------------------------------------
module top_k_sorted_insert
    import tksi_pkg::*;
#(
    parameter int LIST_DEPTH = 50   // 1..64, bounded by the rank port width
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [LABEL_W-1:0]  i_label,
    input  logic [AMOUNT_W-1:0] i_amount,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RANK_W-1:0]   o_rank,
    output logic [LABEL_W-1:0]  o_entry_label,
    output logic [AMOUNT_W-1:0] o_entry_amount,
    output logic                o_last
);

    t_list_cmd cmd;

    // sequencer: request decode, readout rank counter
    tksi_ctrl #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_kind     (i_kind),
        .o_ready    (o_ready),
        .i_out_ready(i_ready),
        .o_out_valid(o_valid),
        .o_rank     (o_rank),
        .o_last     (o_last),
        .o_cmd      (cmd)
    );

    // cell row; the head cell drives the result payload during readout
    tksi_list #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_list (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_label      (i_label),
        .i_amount     (i_amount),
        .o_head_label (o_entry_label),
        .o_head_amount(o_entry_amount)
    );

`ifndef SYNTH
    // no new request is taken while a readout is in flight
    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request accepted during readout");

    // readout ends right after its last result is taken
    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> !o_valid)
        else $error("readout continued past last entry");

    // every readout starts at rank zero
    a_read_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_rank == '0))
        else $error("readout did not start at rank zero");
`endif

endmodule

FILE: tb/sv/tksi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_checker
// Monitors both channels of the top-K list, tracks the expected list contents
// and compares every readout entry, field by field, against that prediction.
// ----------------------------------------------------------------------------
module tksi_checker
    import tksi_pkg::*;
#(
    parameter int LIST_DEPTH = 50
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [LABEL_W-1:0]  i_label,
    input  logic [AMOUNT_W-1:0] i_amount,
    // result channel
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    input  logic [RANK_W-1:0]   i_rank,
    input  logic [LABEL_W-1:0]  i_entry_label,
    input  logic [AMOUNT_W-1:0] i_entry_amount,
    input  logic                i_last,
    output int                  o_errors,
    output int                  o_pending
);

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [LABEL_W-1:0]  label;
        logic [AMOUNT_W-1:0] amount;
        logic                last;
    } t_list_entry;

    // expected list, rank 0 holds the largest amount
    logic [LABEL_W-1:0]  kept_label  [LIST_DEPTH];
    logic [AMOUNT_W-1:0] kept_amount [LIST_DEPTH];
    t_list_entry         readout_q   [$];
    int                  err_cnt = 0;

    task automatic wipe_list();
        for (int k = 0; k < LIST_DEPTH; k++) begin
            kept_label[k]  = '0;
            kept_amount[k] = '0;
        end
    endtask

    // equal amounts: the newcomer goes ahead of the ones already kept
    task automatic insert_offer(input logic [LABEL_W-1:0] lab,
                                input logic [AMOUNT_W-1:0] amt);
        int pos;
        if (kept_amount[LIST_DEPTH-1] > amt)
            return;
        pos = LIST_DEPTH - 1;
        while (pos > 0 && !(kept_amount[pos-1] > amt)) begin
            kept_label[pos]  = kept_label[pos-1];
            kept_amount[pos] = kept_amount[pos-1];
            pos--;
        end
        kept_label[pos]  = lab;
        kept_amount[pos] = amt;
    endtask

    task automatic queue_readout();
        t_list_entry e;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            e.rank   = RANK_W'(k);
            e.label  = kept_label[k];
            e.amount = kept_amount[k];
            e.last   = (k == LIST_DEPTH - 1);
            readout_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_list_entry exp_e;
        if (!i_rst_n) begin
            wipe_list();
            readout_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (readout_q.size() == 0) begin
                    $display("%0t: unexpected result rank %0d label %h amount %h last %b",
                             $time, i_rank, i_entry_label, i_entry_amount, i_last);
                    err_cnt++;
                end else begin
                    exp_e = readout_q.pop_front();
                    if (i_rank !== exp_e.rank) begin
                        $display("%0t: rank mismatch: expected %0d, actual %0d",
                                 $time, exp_e.rank, i_rank);
                        err_cnt++;
                    end
                    if (i_entry_label !== exp_e.label) begin
                        $display("%0t: label mismatch at rank %0d: expected %h, actual %h",
                                 $time, exp_e.rank, exp_e.label, i_entry_label);
                        err_cnt++;
                    end
                    if (i_entry_amount !== exp_e.amount) begin
                        $display("%0t: amount mismatch at rank %0d: expected %h, actual %h",
                                 $time, exp_e.rank, exp_e.amount, i_entry_amount);
                        err_cnt++;
                    end
                    if (i_last !== exp_e.last) begin
                        $display("%0t: last mismatch at rank %0d: expected %b, actual %b",
                                 $time, exp_e.rank, exp_e.last, i_last);
                        err_cnt++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                case (i_kind)
                    KIND_OFFER: insert_offer(i_label, i_amount);
                    KIND_CLEAR: wipe_list();
                    KIND_READ:  queue_readout();
                    default:    ;   // unused kind, no effect
                endcase
            end
        end
        o_errors  <= err_cnt;
        o_pending <= readout_q.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives offer, clear and read requests into the top-K list with bursty
// sender timing and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import tksi_pkg::*;

    localparam int DEPTH         = 50;
    localparam int RANDOM_ITEMS  = 100;
    // cycles with no handshake on either channel before we give up
    localparam int STALL_LIMIT   = 2000;
    // kind code the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                req_valid   = 1'b0;
    logic [KIND_W-1:0]   req_kind    = KIND_OFFER;
    logic [LABEL_W-1:0]  req_label   = '0;
    logic [AMOUNT_W-1:0] req_amount  = '0;
    logic                rsp_ready   = 1'b0;

    logic                dut_ready;
    logic                dut_valid;
    logic [RANK_W-1:0]   dut_rank;
    logic [LABEL_W-1:0]  dut_label;
    logic [AMOUNT_W-1:0] dut_amount;
    logic                dut_last;

    int                  error_count;
    int                  results_pending;

    // sender burst bookkeeping
    int                  burst_left  = 0;
    // recent amount, reused to provoke ties at arbitrary levels
    logic [AMOUNT_W-1:0] recent_amount = '0;

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    top_k_sorted_insert #(
        .LIST_DEPTH (DEPTH)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .o_ready        (dut_ready),
        .i_kind         (req_kind),
        .i_label        (req_label),
        .i_amount       (req_amount),
        .o_valid        (dut_valid),
        .i_ready        (rsp_ready),
        .o_rank         (dut_rank),
        .o_entry_label  (dut_label),
        .o_entry_amount (dut_amount),
        .o_last         (dut_last)
    );

    tksi_checker #(
        .LIST_DEPTH (DEPTH)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_ready    (dut_ready),
        .i_kind         (req_kind),
        .i_label        (req_label),
        .i_amount       (req_amount),
        .i_rsp_valid    (dut_valid),
        .i_rsp_ready    (rsp_ready),
        .i_rank         (dut_rank),
        .i_entry_label  (dut_label),
        .i_entry_amount (dut_amount),
        .i_last         (dut_last),
        .o_errors       (error_count),
        .o_pending      (results_pending)
    );

    // ------------------------------------------------------------------------
    // Receiver: repeatedly picks a random stall mode. Mode 0 never stalls, so
    // long readouts also get stretches at full rate; the periodic mode lands
    // stalls on a fixed beat that drifts against the 50-entry readout.
    // ------------------------------------------------------------------------
    int rx_mode  = 0;
    int rx_count = 0;

    always @(negedge clk) begin
        if (rx_count % 40 == 0)
            rx_mode = $urandom_range(0, 3);
        rx_count++;
        case (rx_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= $urandom_range(0, 1);
            2:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ((rx_count % 5) < 2);
        endcase
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles without any handshake. Covers reset, the final
    // settle time, sender gaps and the longest receiver stall many times over.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((req_valid && dut_ready) || (dut_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, no handshake for %0d cycles",
                     $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    // mix of extremes, near-zero ties, repeated amounts and full-range values
    function automatic logic [AMOUNT_W-1:0] pick_amount();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return AMOUNT_W'($urandom_range(0, 15));
            4:       return recent_amount;
            default: return r[AMOUNT_W-1:0];
        endcase
    endfunction

    // Present one request at the falling edge and hold it until accepted.
    // Between bursts the valid drops for a random gap (possibly none).
    task automatic issue(input logic [KIND_W-1:0]   kind,
                         input logic [LABEL_W-1:0]  lab,
                         input logic [AMOUNT_W-1:0] amt);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        req_valid  <= 1'b1;
        req_kind   <= kind;
        req_label  <= lab;
        req_amount <= amt;
        if (kind == KIND_OFFER)
            recent_amount = amt;
        do
            @(posedge clk);
        while (!dut_ready);
    endtask

    // hold off new requests until every readout entry has been taken
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int                  n_items;
        int                  roll;
        int                  offers_since_clear;
        bit                  drained;
        logic [LABEL_W-1:0]  rnd_label;
        logic [AMOUNT_W-1:0] rnd_amount;

        n_items            = 0;
        offers_since_clear = 0;
        drained            = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part ---------------------------------------------------
        issue(KIND_READ,  16'h0000, '0);              // list straight out of reset
        issue(KIND_OFFER, 16'hFFFF, '1);              // largest amount
        issue(KIND_OFFER, 16'h0000, '0);              // zero equals last rank: kept
        issue(KIND_OFFER, 16'h1234, '0);              // tie lands ahead of older zero
        issue(KIND_OFFER, 16'hAAAA, 48'd1000);
        issue(KIND_OFFER, 16'h5555, 48'd1000);        // tie in the middle of the list
        issue(KIND_OFFER, 16'h0001, '1);              // tie at the top rank
        issue(KIND_OFFER, 16'h8000, 48'h8000_0000_0000);
        issue(KIND_OFFER, 16'h7FFF, 48'h7FFF_FFFF_FFFF);
        issue(KIND_READ,  16'hFFFF, '1);              // payload ignored on read
        issue(KIND_READ,  16'h0000, '0);              // back-to-back reads, list intact
        issue(KIND_UNUSED, 16'hBEEF, 48'hDEAD_BEEF_CAFE); // must be ignored
        issue(KIND_READ,  16'h0000, '0);
        issue(KIND_CLEAR, 16'hFFFF, '1);              // payload ignored on clear
        issue(KIND_READ,  16'h0000, '0);              // all zeros again
        issue(KIND_OFFER, 16'h00FF, 48'd1);
        issue(KIND_CLEAR, 16'h0000, '0);
        issue(KIND_CLEAR, 16'h0000, '0);              // clear of an empty list
        issue(KIND_READ,  16'h0000, '0);

        // --- random part -----------------------------------------------------
        // Mostly offers so the list fills and drops start; clears only once
        // the list has had a chance to overflow.
        while (n_items < RANDOM_ITEMS) begin
            roll       = $urandom_range(0, 99);
            rnd_label  = LABEL_W'($urandom);
            rnd_amount = pick_amount();
            if (roll < 4) begin
                issue(KIND_UNUSED, rnd_label, rnd_amount);   // ignored, not counted
            end else begin
                if (roll < 12) begin
                    issue(KIND_READ, rnd_label, rnd_amount);
                end else if (roll < 20 && offers_since_clear > DEPTH + 10) begin
                    issue(KIND_CLEAR, rnd_label, rnd_amount);
                    offers_since_clear = 0;
                end else begin
                    issue(KIND_OFFER, rnd_label, rnd_amount);
                    offers_since_clear++;
                end
                n_items++;
            end
            if (!drained && n_items == RANDOM_ITEMS / 2) begin
                drain();
                drained = 1'b1;
            end
        end
        // final readout shows the list as it ended up
        issue(KIND_READ, 16'h0000, '0);

        // --- wind down -------------------------------------------------------
        drain();
        // room for any stray result after the last expected one
        repeat (DEPTH + 20) @(posedge clk);
        @(negedge clk);

        if (results_pending != 0)
            $display("%0t: %0d expected results never arrived", $time, results_pending);
        if (error_count == 0 && results_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
